>>> src/stereo_chorus_fractional_delay_defines.svh
// Assertion macros used by the chorus sequencer RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef STEREO_CHORUS_FRACTIONAL_DELAY_DEFINES_SVH
`define STEREO_CHORUS_FRACTIONAL_DELAY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/scfd_pkg.sv
// Shared types, constants and the output rounding function for the chorus block.
// No dependencies; the RTL files refer to it by scoped names and the testbench imports it.
package scfd_pkg;

  localparam int DELAY_DEPTH_DEF = 4096;
  localparam int TABLE_DEPTH_DEF = 65536;

  localparam int SAMPLE_W    = 16;
  localparam int REG_W       = 17;
  localparam int WORD_W      = 28;
  localparam int FRAC_W      = 16;
  localparam int INDEX_W     = 16;
  localparam int PHASE_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int OP_W        = 18;
  localparam int PROD_W      = 2 * OP_W;
  localparam int ACC_W       = 38;

  localparam logic KIND_WORD = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_DRY_GAIN   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WET_GAIN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOD_PERIOD = 2'd2;

  localparam logic [REG_W-1:0] DRY_GAIN_RST   = 17'd39322;
  localparam logic [REG_W-1:0] WET_GAIN_RST   = 17'd26214;
  localparam logic [REG_W-1:0] MOD_PERIOD_RST = 17'd65536;

  localparam logic signed [ACC_W-1:0] RND_POS = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(-32768);

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [INDEX_W-1:0]         table_index;
    logic [WORD_W-1:0]          table_word;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } result_t;

  typedef enum logic [1:0] {
    MAC_NONE,
    MAC_LOAD,
    MAC_ADD,
    MAC_ADD_HI
  } mac_mode_t;

  typedef struct packed {
    mac_mode_t              mode;
    logic signed [OP_W-1:0] op_a;
    logic signed [OP_W-1:0] op_b;
  } mac_ctrl_t;

  // Round Q16 to integer half away from zero, then clamp to int16.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0]    biased;
    logic signed [ACC_W-1:0]    q;
    logic signed [SAMPLE_W-1:0] res;
    biased = acc + (acc[ACC_W-1] ? RND_NEG : RND_POS);
    q = biased >>> FRAC_W;
    if (q > SAT_HI) begin
      res = SAMPLE_W'(SAT_HI);
    end else if (q < SAT_LO) begin
      res = SAMPLE_W'(SAT_LO);
    end else begin
      res = q[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> src/stereo_chorus_fractional_delay.sv
// Top level of the stereo chorus: configuration registers, memories, MAC and sequencer.
// Depends on scfd_pkg, scfd_ram, scfd_mac and scfd_seq.
//
// Stereo chorus with a tabled fractional delay. A kind-1 beat loads one Q16 delay word
// into the table (clamped to the longest usable delay) and gives no result. A kind-0
// beat is an audio frame: it is written into the two history lines, the delay for the
// current modulation phase is looked up, two adjacent taps per channel are fetched
// through the single read port of each history RAM, and the interpolation and dry/wet
// mix run through one shared 18x18 multiplier, five products per channel. The ten
// multiplier passes follow the table and history reads, and the block accepts nothing
// else from acceptance to the result beat. The output register lets the next item in
// while a result still waits. History entries not yet written since reset read as
// zero through a fill count, so no clearing pass is needed. Configuration writes take
// effect at once and must only be made while the block is idle.
module stereo_chorus_fractional_delay #(
  parameter int DELAY_DEPTH = scfd_pkg::DELAY_DEPTH_DEF,
  parameter int TABLE_DEPTH = scfd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  scfd_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output scfd_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [scfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scfd_pkg::REG_W-1:0]          cfg_data
);

  localparam int DAW = $clog2(DELAY_DEPTH);
  localparam int TAW = $clog2(TABLE_DEPTH);

  logic [scfd_pkg::REG_W-1:0]            dry_gain;
  logic [scfd_pkg::REG_W-1:0]            wet_gain;
  logic [scfd_pkg::REG_W-1:0]            modulation_period;

  logic                                  table_we;
  logic [TAW-1:0]                        table_waddr;
  logic [scfd_pkg::WORD_W-1:0]           table_wdata;
  logic [TAW-1:0]                        table_raddr;
  logic [scfd_pkg::WORD_W-1:0]           table_rdata;
  logic                                  hist_we;
  logic [DAW-1:0]                        hist_waddr;
  logic [DAW-1:0]                        hist_raddr;
  logic [scfd_pkg::SAMPLE_W-1:0]         hist_l_raw;
  logic [scfd_pkg::SAMPLE_W-1:0]         hist_r_raw;
  scfd_pkg::mac_ctrl_t                   mac_ctrl;
  logic signed [scfd_pkg::PROD_W-1:0]    mac_prod;
  logic signed [scfd_pkg::ACC_W-1:0]     mac_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_gain          <= scfd_pkg::DRY_GAIN_RST;
      wet_gain          <= scfd_pkg::WET_GAIN_RST;
      modulation_period <= scfd_pkg::MOD_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        scfd_pkg::CFG_DRY_GAIN:   dry_gain          <= cfg_data;
        scfd_pkg::CFG_WET_GAIN:   wet_gain          <= cfg_data;
        scfd_pkg::CFG_MOD_PERIOD: modulation_period <= cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  scfd_ram #(
    .WIDTH (scfd_pkg::WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (table_waddr),
    .wdata (table_wdata),
    .raddr (table_raddr),
    .rdata (table_rdata)
  );

  scfd_ram #(
    .WIDTH (scfd_pkg::SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_hist_l (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (item.left_sample),
    .raddr (hist_raddr),
    .rdata (hist_l_raw)
  );

  scfd_ram #(
    .WIDTH (scfd_pkg::SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_hist_r (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (item.right_sample),
    .raddr (hist_raddr),
    .rdata (hist_r_raw)
  );

  scfd_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .prod (mac_prod),
    .acc  (mac_acc)
  );

  scfd_seq #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item              (item),
    .item_stall        (item_stall),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .result            (result),
    .dry_gain          (dry_gain),
    .wet_gain          (wet_gain),
    .modulation_period (modulation_period),
    .table_we          (table_we),
    .table_waddr       (table_waddr),
    .table_wdata       (table_wdata),
    .table_raddr       (table_raddr),
    .table_rdata       (table_rdata),
    .hist_we           (hist_we),
    .hist_waddr        (hist_waddr),
    .hist_raddr        (hist_raddr),
    .hist_l_rdata      ($signed(hist_l_raw)),
    .hist_r_rdata      ($signed(hist_r_raw)),
    .mac_ctrl          (mac_ctrl),
    .mac_prod          (mac_prod),
    .mac_acc           (mac_acc)
  );

endmodule

>>> src/scfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on scfd_pkg for default sizes only.
module scfd_ram #(
  parameter int WIDTH = scfd_pkg::SAMPLE_W,
  parameter int DEPTH = scfd_pkg::DELAY_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/scfd_mac.sv
// Shared 18x18 signed multiplier with a registered product and an accumulator.
// Depends on scfd_pkg for the control struct and widths.
module scfd_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  scfd_pkg::mac_ctrl_t                  ctrl,
  output logic signed [scfd_pkg::PROD_W-1:0]   prod,
  output logic signed [scfd_pkg::ACC_W-1:0]    acc
);

  logic signed [scfd_pkg::PROD_W-1:0] prod_next;
  scfd_pkg::mac_mode_t                mode_d;

  always_comb begin
    prod_next = $signed(ctrl.op_a) * $signed(ctrl.op_b);
  end

  // The accumulate step acts in the cycle after the multiply, on the registered product.
  always_ff @(posedge clk) begin
    prod <= prod_next;
    unique case (mode_d)
      scfd_pkg::MAC_LOAD:   acc <= scfd_pkg::ACC_W'(prod);
      scfd_pkg::MAC_ADD:    acc <= acc + scfd_pkg::ACC_W'(prod);
      scfd_pkg::MAC_ADD_HI: acc <= acc + scfd_pkg::ACC_W'(prod >>> scfd_pkg::FRAC_W);
      default:              acc <= acc;
    endcase
    if (rst) begin
      mode_d <= scfd_pkg::MAC_NONE;
    end else begin
      mode_d <= ctrl.mode;
    end
  end

endmodule

>>> src/scfd_seq.sv
// Frame sequencer: table and history addressing, tap fetch, MAC schedule, output register.
// Depends on scfd_pkg and on the assertion macros header.
`include "stereo_chorus_fractional_delay_defines.svh"

module scfd_seq #(
  parameter int DELAY_DEPTH = scfd_pkg::DELAY_DEPTH_DEF,
  parameter int TABLE_DEPTH = scfd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    item_valid,
  input  scfd_pkg::item_t                         item,
  output logic                                    item_stall,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output scfd_pkg::result_t                       result,
  input  logic [scfd_pkg::REG_W-1:0]              dry_gain,
  input  logic [scfd_pkg::REG_W-1:0]              wet_gain,
  input  logic [scfd_pkg::REG_W-1:0]              modulation_period,
  output logic                                    table_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]          table_waddr,
  output logic [scfd_pkg::WORD_W-1:0]             table_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0]          table_raddr,
  input  logic [scfd_pkg::WORD_W-1:0]             table_rdata,
  output logic                                    hist_we,
  output logic [$clog2(DELAY_DEPTH)-1:0]          hist_waddr,
  output logic [$clog2(DELAY_DEPTH)-1:0]          hist_raddr,
  input  logic signed [scfd_pkg::SAMPLE_W-1:0]    hist_l_rdata,
  input  logic signed [scfd_pkg::SAMPLE_W-1:0]    hist_r_rdata,
  output scfd_pkg::mac_ctrl_t                     mac_ctrl,
  input  logic signed [scfd_pkg::PROD_W-1:0]      mac_prod,
  input  logic signed [scfd_pkg::ACC_W-1:0]       mac_acc
);

  localparam int DAW = $clog2(DELAY_DEPTH);
  localparam int FW  = $clog2(DELAY_DEPTH + 1);
  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int SW  = scfd_pkg::SAMPLE_W;
  localparam int OW  = scfd_pkg::OP_W;
  localparam int FRW = scfd_pkg::FRAC_W;

  // Largest delay word: integer part DELAY_DEPTH-2, full fraction, capped at word width.
  localparam logic [63:0] TOP_RAW = (64'(DELAY_DEPTH - 2) << FRW) | 64'hFFFF;
  localparam logic [scfd_pkg::WORD_W-1:0] TOP_WORD =
    (TOP_RAW > 64'h0FFF_FFFF) ? {scfd_pkg::WORD_W{1'b1}} : scfd_pkg::WORD_W'(TOP_RAW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WORD,
    S_RDA,
    S_RDB,
    S_GETB,
    S_DIFF,
    S_HI,
    S_LO,
    S_A,
    S_DRY,
    S_WAIT,
    S_ROUND,
    S_OUT
  } state_t;

  state_t                        state;
  logic                          ch;
  logic [scfd_pkg::PHASE_W-1:0]  phase;
  logic [DAW-1:0]                pos;
  logic [FW-1:0]                 fill;
  logic                          phase_ok;
  logic [DAW-1:0]                d_reg;
  logic [FRW-1:0]                frac;
  logic [DAW-1:0]                pa;
  logic                          ok_a;
  logic                          ok_b;
  logic signed [SW-1:0]          smp_l;
  logic signed [SW-1:0]          smp_r;
  logic signed [SW-1:0]          a_l;
  logic signed [SW-1:0]          a_r;
  logic signed [SW-1:0]          b_l;
  logic signed [SW-1:0]          b_r;
  logic [FRW-1:0]                p_lo;
  logic signed [SW-1:0]          left_res;
  logic signed [SW-1:0]          right_res;

  logic                          frame_acc;
  logic                          word_acc;
  logic [scfd_pkg::REG_W-1:0]    phase_inc;
  logic [scfd_pkg::WORD_W-1:0]   word_rd;
  logic [DAW:0]                  pa_diff;
  logic [DAW-1:0]                pa_calc;
  logic [DAW-1:0]                pb_calc;
  logic signed [SW-1:0]          cur_a;
  logic signed [SW-1:0]          cur_b;
  logic signed [SW-1:0]          cur_x;
  logic signed [SW-1:0]          rounded;

  assign item_stall = (state != S_IDLE);
  assign frame_acc  = item_valid && !item_stall && (item.kind != scfd_pkg::KIND_WORD);
  assign word_acc   = item_valid && !item_stall && (item.kind == scfd_pkg::KIND_WORD);

  // Table load: clamp the word, drop indexes beyond the table.
  assign table_we    = word_acc && (32'(item.table_index) < TABLE_DEPTH);
  assign table_waddr = TAW'(item.table_index);
  assign table_wdata = (item.table_word > TOP_WORD) ? TOP_WORD : item.table_word;
  assign table_raddr = TAW'(phase);

  assign hist_we    = frame_acc;
  assign hist_waddr = pos;

  assign phase_inc = {1'b0, phase} + scfd_pkg::REG_W'(1);
  assign word_rd   = phase_ok ? table_rdata : '0;

  // Tap addresses, modulo the history depth.
  always_comb begin
    pa_diff = {1'b0, pos} - {1'b0, d_reg};
    pa_calc = pa_diff[DAW] ? DAW'(pa_diff + (DAW + 1)'(DELAY_DEPTH)) : pa_diff[DAW-1:0];
    pb_calc = (pa == '0) ? DAW'(DELAY_DEPTH - 1) : pa - 1'b1;
    hist_raddr = (state == S_RDB) ? pb_calc : pa_calc;
  end

  assign cur_a   = ch ? a_r : a_l;
  assign cur_b   = ch ? b_r : b_l;
  assign cur_x   = ch ? smp_r : smp_l;
  assign rounded = scfd_pkg::round_sat(mac_acc);

  // Per channel: p = (b-a)*f, then g*p_hi + (g*p_lo >> 16) + g*a + dry*x.
  always_comb begin
    mac_ctrl.mode = scfd_pkg::MAC_NONE;
    mac_ctrl.op_a = '0;
    mac_ctrl.op_b = '0;
    unique case (state)
      S_DIFF: begin
        mac_ctrl.op_a = OW'(cur_b) - OW'(cur_a);
        mac_ctrl.op_b = $signed({2'b00, frac});
      end
      S_HI: begin
        mac_ctrl.mode = scfd_pkg::MAC_LOAD;
        mac_ctrl.op_a = $signed({1'b0, wet_gain});
        mac_ctrl.op_b = $signed(mac_prod[FRW +: OW]);
      end
      S_LO: begin
        mac_ctrl.mode = scfd_pkg::MAC_ADD_HI;
        mac_ctrl.op_a = $signed({1'b0, wet_gain});
        mac_ctrl.op_b = $signed({2'b00, p_lo});
      end
      S_A: begin
        mac_ctrl.mode = scfd_pkg::MAC_ADD;
        mac_ctrl.op_a = $signed({1'b0, wet_gain});
        mac_ctrl.op_b = OW'(cur_a);
      end
      S_DRY: begin
        mac_ctrl.mode = scfd_pkg::MAC_ADD;
        mac_ctrl.op_a = $signed({1'b0, dry_gain});
        mac_ctrl.op_b = OW'(cur_x);
      end
      default: begin
        mac_ctrl.mode = scfd_pkg::MAC_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ch           <= 1'b0;
      phase        <= '0;
      pos          <= '0;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      // Raise the result beat when the output step loads it, drop it once taken.
      if (state == S_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (frame_acc) begin
            smp_l    <= item.left_sample;
            smp_r    <= item.right_sample;
            phase_ok <= (32'(phase) < TABLE_DEPTH);
            phase    <= (phase_inc >= modulation_period) ? '0 : phase_inc[scfd_pkg::PHASE_W-1:0];
            if (fill != FW'(DELAY_DEPTH)) begin
              fill <= fill + FW'(1);
            end
            state <= S_WORD;
          end
        end
        S_WORD: begin
          d_reg <= DAW'(word_rd[scfd_pkg::WORD_W-1:FRW]);
          frac  <= word_rd[FRW-1:0];
          state <= S_RDA;
        end
        S_RDA: begin
          pa    <= pa_calc;
          ok_a  <= (FW'(pa_calc) < fill);
          state <= S_RDB;
        end
        S_RDB: begin
          // Entries never written since reset read as silence.
          a_l   <= ok_a ? hist_l_rdata : '0;
          a_r   <= ok_a ? hist_r_rdata : '0;
          ok_b  <= (FW'(pb_calc) < fill);
          state <= S_GETB;
        end
        S_GETB: begin
          b_l   <= ok_b ? hist_l_rdata : '0;
          b_r   <= ok_b ? hist_r_rdata : '0;
          pos   <= (pos == DAW'(DELAY_DEPTH - 1)) ? '0 : pos + 1'b1;
          ch    <= 1'b0;
          state <= S_DIFF;
        end
        S_DIFF: state <= S_HI;
        S_HI: begin
          p_lo  <= mac_prod[FRW-1:0];
          state <= S_LO;
        end
        S_LO:   state <= S_A;
        S_A:    state <= S_DRY;
        S_DRY:  state <= S_WAIT;
        S_WAIT: state <= S_ROUND;
        S_ROUND: begin
          if (!ch) begin
            left_res <= rounded;
            ch       <= 1'b1;
            state    <= S_DIFF;
          end else begin
            right_res <= rounded;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free or being emptied.
          if (!result_valid || !result_stall) begin
            result.left_out  <= left_res;
            result.right_out <= right_res;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SCFD_ASSERT_NEXT(a_frame_holds_off, frame_acc, item_stall, "frame accepted but still ready")
  `SCFD_ASSERT_NEXT(a_word_one_beat, word_acc, state == S_IDLE, "table load left idle")
  `SCFD_ASSERT_NOW(a_tap_in_range, (state == S_RDA) || (state == S_RDB), 32'(hist_raddr) < DELAY_DEPTH, "tap address beyond history")
  `SCFD_ASSERT_NOW(a_fill_bounded, 1'b1, 32'(fill) <= DELAY_DEPTH, "fill count beyond history depth")
  `SCFD_ASSERT_NOW(a_result_from_out, $rose(result_valid), $past(state) == S_OUT, "result raised outside output step")

endmodule

>>> tb/tb_stereo_chorus_fractional_delay.sv
// Self-checking testbench for the stereo chorus block: table loads and audio frames
// are predicted in a small scoreboard and compared beat by beat with the result channel.
// Depends on scfd_pkg and stereo_chorus_fractional_delay.
`timescale 1ns / 100ps

module tb_stereo_chorus_fractional_delay;
  import scfd_pkg::*;

  localparam int POS_W        = $clog2(DELAY_DEPTH_DEF);
  localparam int ONE_Q16      = 65536;
  localparam int HALF_Q16     = 32768;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 100;
  localparam logic KIND_FRAME = ~KIND_WORD;
  localparam logic [WORD_W-1:0] TOP_WORD =
    WORD_W'(((DELAY_DEPTH_DEF - 2) << FRAC_W) | 16'hFFFF);

  class chorus_scoreboard;
    logic signed [SAMPLE_W-1:0] left_hist  [DELAY_DEPTH_DEF];
    logic signed [SAMPLE_W-1:0] right_hist [DELAY_DEPTH_DEF];
    logic [WORD_W-1:0]          delays     [TABLE_DEPTH_DEF];
    bit                         loaded     [TABLE_DEPTH_DEF];
    logic [POS_W-1:0]           wr_pos;
    logic [PHASE_W-1:0]         phase;
    logic [REG_W-1:0]           dry_gain;
    logic [REG_W-1:0]           wet_gain;
    logic [REG_W-1:0]           period;
    result_t                    expected_frames[$];
    int                         frames;
    int                         words;
    int                         mismatches;

    function new();
      foreach (left_hist[i]) begin
        left_hist[i]  = '0;
        right_hist[i] = '0;
      end
      foreach (loaded[i]) loaded[i] = 1'b0;
      wr_pos     = '0;
      phase      = '0;
      dry_gain   = DRY_GAIN_RST;
      wet_gain   = WET_GAIN_RST;
      period     = MOD_PERIOD_RST;
      frames     = 0;
      words      = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] value);
      case (idx)
        CFG_DRY_GAIN:   dry_gain = value;
        CFG_WET_GAIN:   wet_gain = value;
        CFG_MOD_PERIOD: period   = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // Interpolate between the two taps, mix with the dry sample, round and clamp.
    function logic signed [SAMPLE_W-1:0] mix_sample(logic signed [SAMPLE_W-1:0] dry, tap_a,
                                                    tap_b, logic [FRAC_W-1:0] frac);
      longint wet;
      longint acc;
      longint q;
      wet = longint'(tap_a) * (longint'(ONE_Q16) - longint'(frac))
          + longint'(tap_b) * longint'(frac);
      acc = longint'(dry_gain) * longint'(dry) + ((longint'(wet_gain) * wet) >>> FRAC_W);
      if (acc >= 0) begin
        q = (acc + HALF_Q16) >>> FRAC_W;
      end else begin
        q = -((-acc + HALF_Q16) >>> FRAC_W);
      end
      if (q > 32767) begin
        q = 32767;
      end else if (q < -32768) begin
        q = -32768;
      end
      return SAMPLE_W'(q);
    endfunction

    function void note_item(item_t it);
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  tap_a;
      logic [POS_W-1:0]  tap_b;
      int                nxt;
      result_t           predicted;
      if (it.kind == KIND_WORD) begin
        // clamp to the longest usable delay
        word = (it.table_word > TOP_WORD) ? TOP_WORD : it.table_word;
        delays[it.table_index] = word;
        loaded[it.table_index] = 1'b1;
        words++;
      end else begin
        word = delays[phase];
        nxt = int'(phase) + 1;
        if (nxt >= int'(period)) nxt = 0;
        phase = PHASE_W'(nxt);
        left_hist[wr_pos]  = it.left_sample;
        right_hist[wr_pos] = it.right_sample;
        tap_a = wr_pos - POS_W'(word >> FRAC_W);
        tap_b = tap_a - 1'b1;
        predicted.left_out  = mix_sample(it.left_sample, left_hist[tap_a], left_hist[tap_b],
                                         word[FRAC_W-1:0]);
        predicted.right_out = mix_sample(it.right_sample, right_hist[tap_a], right_hist[tap_b],
                                         word[FRAC_W-1:0]);
        expected_frames.push_back(predicted);
        wr_pos++;
        frames++;
      end
    endfunction

    function void report(string field, logic signed [SAMPLE_W-1:0] want, got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected: expected none, got %0d / %0d",
                 $time, got.left_out, got.right_out);
        return;
      end
      want = expected_frames.pop_front();
      if (got.left_out !== want.left_out) report("left_out", want.left_out, got.left_out);
      if (got.right_out !== want.right_out) report("right_out", want.right_out, got.right_out);
    endfunction
  endclass

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [REG_W-1:0]       cfg_data     = '0;

  chorus_scoreboard sb = new();
  int send_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  stereo_chorus_fractional_delay dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles at %0t", STALL_LIMIT, $time);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input item_t it);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_word(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] word);
    item_t it;
    it.kind         = KIND_WORD;
    it.left_sample  = SAMPLE_W'($urandom);
    it.right_sample = SAMPLE_W'($urandom);
    it.table_index  = idx;
    it.table_word   = word;
    send_item(it);
  endtask

  function automatic logic [WORD_W-1:0] random_delay();
    case ($urandom_range(9))
      0:       return WORD_W'($urandom);
      1:       return {12'hFFF - 12'($urandom_range(1)), 16'($urandom)};
      2, 3, 4: return {12'($urandom_range(15)), 16'($urandom)};
      default: return {12'($urandom_range(700)), 16'($urandom)};
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l, r);
    item_t it;
    // load the entry at the current phase first if it has never been written
    if (!sb.loaded[sb.phase]) send_word(sb.phase, random_delay());
    it.kind         = KIND_FRAME;
    it.left_sample  = l;
    it.right_sample = r;
    it.table_index  = INDEX_W'($urandom);
    it.table_word   = WORD_W'($urandom);
    send_item(it);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [REG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // Drain the block, then load a new register setting.
  task automatic apply_setting(input logic [REG_W-1:0] dry, wet, per);
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_register(CFG_DRY_GAIN, dry);
    write_register(CFG_WET_GAIN, wet);
    write_register(CFG_MOD_PERIOD, per);
    cfg_write <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(1) == 0)
          send_word(INDEX_W'(sb.phase + $urandom_range(8)), random_delay());
        else
          send_word(INDEX_W'($urandom), random_delay());
      end else begin
        send_frame(random_sample(), random_sample());
      end
    end
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] dir_left  [8];
    logic signed [SAMPLE_W-1:0] dir_right [8];
    dir_left  = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                  16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh0000};
    dir_right = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001,
                  16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh7FFF};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero delay, top word, oversize word, half fraction, last index.
    send_word(16'd0, '0);
    send_word(16'd1, TOP_WORD);
    send_word(16'd2, {WORD_W{1'b1}});
    send_word(16'd3, {12'd1, 16'h8000});
    send_word(16'hFFFF, {12'd2, 16'hFFFF});
    send_word(16'd4, {12'd1, 16'hFFFF});
    for (int i = 0; i < 8; i++) send_frame(dir_left[i], dir_right[i]);

    // Unity gains, zero period: the phase returns to zero after every frame.
    apply_setting(REG_W'(ONE_Q16), REG_W'(ONE_Q16), '0);
    run_random(100);

    // Largest gains, period of one; sender idles often.
    apply_setting('1, '1, REG_W'(1));
    send_pct = 79;
    run_random(100);

    // No dry path, period beyond the phase range; receiver stalls often.
    apply_setting('0, REG_W'(ONE_Q16), '1);
    send_pct  = 0;
    stall_pct = 79;
    run_random(100);

    // Random gains, short period so table entries are revisited; both sides idle.
    apply_setting(REG_W'($urandom_range(ONE_Q16)), REG_W'($urandom_range(ONE_Q16)),
                  REG_W'($urandom_range(40, 2)));
    send_pct  = 32;
    stall_pct = 32;
    run_random(100);

    // Dry only, full period.
    apply_setting(REG_W'(ONE_Q16), '0, REG_W'(ONE_Q16));
    send_pct  = 0;
    stall_pct = 0;
    run_random(100);

    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d audio frames and %0d delay table loads over six register",
             sb.frames, sb.words);
    $display("settings, with sender gaps and result stalls in separate and joint phases.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
